>>> src/crs_pkg.sv
package crs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;
  localparam int CRD_W      = 32;
  localparam int PAR_W      = 17;
  localparam int COEF_W     = 36;
  localparam int ACC_W      = 56;

  localparam logic [PAR_W-1:0] ONE_Q16   = PAR_W'(65536);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_POINTS);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_COEF,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       take_write;
    logic       take_eval;
    logic       seg_en;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       u2_en;
    logic       u3_en;
    logic       coef_en;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       fin_en;
  } ctrl_t;

  typedef struct packed {
    logic out_full;
    logic out_ready;
  } stat_t;

endpackage

>>> src/crs_in_if.sv
interface crs_in_if import crs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [IDX_W-1:0]        point_index;
  logic signed [CRD_W-1:0] point_x;
  logic signed [CRD_W-1:0] point_y;
  logic signed [CRD_W-1:0] point_z;
  logic [PAR_W-1:0]        curve_param;

  modport source (output valid, command, point_index, point_x, point_y, point_z,
                  curve_param, input ready);
  modport sink (input valid, command, point_index, point_x, point_y, point_z,
                curve_param, output ready);
endinterface

>>> src/crs_out_if.sv
interface crs_out_if import crs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] pos_x;
  logic signed [CRD_W-1:0] pos_y;
  logic signed [CRD_W-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

>>> src/crs_ctrl.sv
module crs_ctrl import crs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_command_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_command_i == CMD_EVAL) state_d = ST_SEG;
      end
      ST_SEG:  state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_COEF;
      ST_COEF: state_d = ST_MUL0;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_FIN;
      ST_FIN: begin
        if (!stat_i.out_full || stat_i.out_ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o         = 1'b1;
        ctrl_o.take_write  = in_valid_i && in_command_i == CMD_WRITE;
        ctrl_o.take_eval   = in_valid_i && in_command_i == CMD_EVAL;
      end
      ST_SEG: ctrl_o.seg_en = 1'b1;
      ST_RD0: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = 2'd0;
        ctrl_o.u2_en  = 1'b1;
      end
      ST_RD1: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.rd_sel  = 2'd1;
        ctrl_o.cap_en  = 1'b1;
        ctrl_o.cap_sel = 2'd0;
        ctrl_o.u3_en   = 1'b1;
      end
      ST_RD2: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.rd_sel  = 2'd2;
        ctrl_o.cap_en  = 1'b1;
        ctrl_o.cap_sel = 2'd1;
      end
      ST_RD3: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.rd_sel  = 2'd3;
        ctrl_o.cap_en  = 1'b1;
        ctrl_o.cap_sel = 2'd2;
      end
      ST_COEF: ctrl_o.coef_en = 1'b1;
      ST_MUL0: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = 2'd0;
      end
      ST_MUL1: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = 2'd1;
      end
      ST_MUL2: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = 2'd2;
      end
      ST_FIN: ctrl_o.fin_en = !stat_i.out_full || stat_i.out_ready;
      default: ctrl_o = '0;
    endcase
  end

endmodule

>>> src/crs_dpath.sv
module crs_dpath import crs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  output stat_t                   stat_o,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_wdata_i,
  input  logic [IDX_W-1:0]        point_index_i,
  input  logic signed [CRD_W-1:0] point_x_i,
  input  logic signed [CRD_W-1:0] point_y_i,
  input  logic signed [CRD_W-1:0] point_z_i,
  input  logic [PAR_W-1:0]        curve_param_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [CRD_W-1:0] pos_x_o,
  output logic signed [CRD_W-1:0] pos_y_o,
  output logic signed [CRD_W-1:0] pos_z_o
);

  logic [CNT_W-1:0] count_q;
  logic [PAR_W-1:0] t_q;
  logic [IDX_W-1:0] div_q;
  logic [IDX_W-1:0] idx_q [4];
  logic [PAR_W-1:0] u_q, u2_q, u3_q;
  logic             out_valid_q;
  logic signed [CRD_W-1:0] pos_q [3];

  logic [CRD_W-1:0] mem_x [MAX_POINTS];
  logic [CRD_W-1:0] mem_y [MAX_POINTS];
  logic [CRD_W-1:0] mem_z [MAX_POINTS];
  logic signed [CRD_W-1:0] rdata_q [3];
  logic signed [CRD_W-1:0] p_q [3][3];
  logic signed [COEF_W-1:0] a_q [3], b_q [3], c_q [3];
  logic signed [ACC_W-1:0]  acc_q [3];

  logic [CNT_W-1:0]   n_c;
  logic [IDX_W-1:0]   div_c;
  logic [PAR_W-1:0]   t_c;
  logic [22:0]        s_c;
  logic [CNT_W-1:0]   seg_c, div7_c, nxt1_c, nxt2_c;
  logic [2*PAR_W-1:0] usq_c, ucb_c;
  logic [IDX_W-1:0]   raddr_c;
  logic [PAR_W-1:0]   mop_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // clamp parameter and point count at accept
  always_comb begin
    n_c = count_q;
    if (count_q < CNT_MIN) n_c = CNT_MIN;
    if (count_q > CNT_MAX) n_c = CNT_MAX;
    div_c = IDX_W'(n_c - CNT_W'(1));
    t_c   = (curve_param_i > ONE_Q16) ? ONE_Q16 : curve_param_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_eval) begin
      t_q   <= t_c;
      div_q <= div_c;
    end
  end

  always_comb begin
    s_c    = 23'(t_q) * 23'(div_q);
    div7_c = CNT_W'(div_q);
    seg_c  = s_c[22:16];
    if (seg_c >= div7_c) seg_c = div7_c - CNT_W'(1);
    nxt1_c = seg_c + CNT_W'(1);
    nxt2_c = seg_c + CNT_W'(2);
    if (nxt1_c > div7_c) nxt1_c = div7_c;
    if (nxt2_c > div7_c) nxt2_c = div7_c;
    usq_c = u_q * u_q;
    ucb_c = u2_q * u_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.seg_en) begin
      idx_q[0] <= (seg_c == '0) ? '0 : IDX_W'(seg_c - CNT_W'(1));
      idx_q[1] <= IDX_W'(seg_c);
      idx_q[2] <= IDX_W'(nxt1_c);
      idx_q[3] <= IDX_W'(nxt2_c);
      // end of curve: last segment with full fraction
      if (s_c[22:16] >= div7_c) u_q <= ONE_Q16;
      else                      u_q <= {1'b0, s_c[15:0]};
    end
    if (ctrl_i.u2_en) u2_q <= usq_c[2*PAR_W-2:16];
    if (ctrl_i.u3_en) u3_q <= ucb_c[2*PAR_W-2:16];
  end

  assign raddr_c = idx_q[ctrl_i.rd_sel];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_write) begin
      mem_x[point_index_i] <= point_x_i;
      mem_y[point_index_i] <= point_y_i;
      mem_z[point_index_i] <= point_z_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q[0] <= mem_x[raddr_c];
      rdata_q[1] <= mem_y[raddr_c];
      rdata_q[2] <= mem_z[raddr_c];
    end
  end

  always_comb begin
    case (ctrl_i.mul_sel)
      2'd0:    mop_c = u_q;
      2'd1:    mop_c = u2_q;
      2'd2:    mop_c = u3_q;
      default: mop_c = u_q;
    endcase
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    logic signed [COEF_W-1:0] e0, e1, e2, e3, cop;
    logic signed [COEF_W+PAR_W:0] prod;
    logic signed [ACC_W-1:0] base, rsum;
    logic signed [ACC_W-18:0] r;

    assign e0 = COEF_W'(p_q[ax][0]);
    assign e1 = COEF_W'(p_q[ax][1]);
    assign e2 = COEF_W'(p_q[ax][2]);
    assign e3 = COEF_W'(rdata_q[ax]);

    always_comb begin
      case (ctrl_i.mul_sel)
        2'd0:    cop = a_q[ax];
        2'd1:    cop = b_q[ax];
        2'd2:    cop = c_q[ax];
        default: cop = a_q[ax];
      endcase
      prod = cop * $signed({1'b0, mop_c});
      base = (ctrl_i.mul_sel == 2'd0) ? (ACC_W'(p_q[ax][1]) <<< 17) : acc_q[ax];
      rsum = acc_q[ax] + ACC_W'(65536);
      r    = rsum[ACC_W-1:17];
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.cap_en) p_q[ax][ctrl_i.cap_sel] <= rdata_q[ax];
      if (ctrl_i.coef_en) begin
        a_q[ax] <= e2 - e0;
        b_q[ax] <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        c_q[ax] <= e1 + (e1 <<< 1) - e0 - e2 - (e2 <<< 1) + e3;
      end
      if (ctrl_i.mul_en) acc_q[ax] <= base + ACC_W'(prod);
      if (ctrl_i.fin_en) begin
        if (r > (ACC_W-17)'(32'sh7FFF_FFFF))       pos_q[ax] <= 32'sh7FFF_FFFF;
        else if (r < -(ACC_W-17)'(64'sh8000_0000)) pos_q[ax] <= 32'sh8000_0000;
        else                                       pos_q[ax] <= r[CRD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.fin_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_full  = out_valid_q;
  assign stat_o.out_ready = out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign pos_x_o          = pos_q[0];
  assign pos_y_o          = pos_q[1];
  assign pos_z_o          = pos_q[2];

endmodule

>>> src/catmull_rom_spline_evaluator_unit.sv
// An evaluate word steps through SEG, RD0 to RD3, COEF, MUL0 to MUL2 and FIN.
// A new one is taken only in idle, after four reads through the
// single read port of the point store and three multiply steps per axis.
// A result register lets the next word in early; FIN holds while it is full
// and not being taken. Reset clears the sequencer and output valid and sets
// point_count to 4; the point store holds no reset value until written.
module catmull_rom_spline_evaluator_unit import crs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  crs_in_if.sink           in_i,
  crs_out_if.source        out_o
);

  ctrl_t ctrl;
  stat_t stat;

  crs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  crs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_index_i (in_i.point_index),
    .point_x_i     (in_i.point_x),
    .point_y_i     (in_i.point_y),
    .point_z_i     (in_i.point_z),
    .curve_param_i (in_i.curve_param),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .pos_x_o       (out_o.pos_x),
    .pos_y_o       (out_o.pos_y),
    .pos_z_o       (out_o.pos_z)
  );

endmodule
